/* rtl/ccs_pkg.sv */
// Connected-component search: shared types and constants.
// Used by ccs_lsb_unit and connected_component_search; no dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

  // Graph size and field widths
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VidW        = 6;   // vertex id width
  localparam int unsigned CntW        = 7;   // count width, holds MaxVertices itself

  typedef logic [MaxVertices-1:0] row_t;
  typedef logic [VidW-1:0]        vid_t;
  typedef logic [CntW-1:0]        cnt_t;

  // Request function codes
  localparam logic [1:0] FuncAddEdge = 2'd0;
  localparam logic [1:0] FuncQuery   = 2'd1;
  localparam logic [1:0] FuncClear   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgVertexCount = 2'd0;
  localparam logic [1:0] CfgStartVertex = 2'd1;

  // Result of the lowest-set-bit unit
  typedef struct packed {
    logic found;  // word had at least one bit set
    vid_t idx;    // position of the lowest set bit
    row_t rest;   // word with that bit cleared
  } lsb_res_t;

endpackage

/* rtl/connected_component_search.sv */
// Connected-component search over an undirected graph held as an adjacency bit matrix.
// Top level; depends on ccs_pkg and ccs_lsb_unit.
`timescale 1ns / 1ps

// Usage
//   Request channel (in_valid_i / in_ready_o) carries func_i, edge_from_i, edge_to_i:
//   add edge, run query, or clear graph. Result channel (out_valid_o / out_ready_i)
//   carries one member vertex per result, ascending, with component_size_o and last_o.
//   cfg_we_i/cfg_idx_i/cfg_data_i write vertex_count (0) and start_vertex (1), idle only.
// Timing
//   One request at a time; in_ready_o is high only while the sequencer is idle.
//   Clear is done in the idle state. Add edge does two read-modify-writes of the adjacency
//   memory with registered read; an endpoint out of range leaves the sequencer idle. Query
//   steps pop, address, row read and push for each visited vertex, then emits the members;
//   a start vertex out of range leaves the sequencer idle.
//   The walk is paced by the stack and adjacency memory reads and by the shared
//   lowest-set-bit unit, which pushes one neighbour or emits one member a cycle unless the output stalls.
// Reset and stall
//   Reset clears every row-valid bit (empty graph), sets vertex_count to 64 and
//   start_vertex to 0; no clearing pass is needed. A stalled receiver holds the result
//   in the output register and the emit phase waits; nothing is lost.

module connected_component_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [6:0]           cfg_data_i,
  // requests
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  ccs_pkg::vid_t        edge_from_i,
  input  ccs_pkg::vid_t        edge_to_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ccs_pkg::vid_t        member_vertex_o,
  output ccs_pkg::cnt_t        component_size_o,
  output logic                 last_o
);

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SEdgeWrA = 9'b000000010,
    SEdgeRdB = 9'b000000100,
    SEdgeWrB = 9'b000001000,
    SPop     = 9'b000010000,
    SAddr    = 9'b000100000,
    SRow     = 9'b001000000,
    SPush    = 9'b010000000,
    SEmit    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  ccs_pkg::cnt_t vertex_count_q;
  ccs_pkg::vid_t start_vertex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= ccs_pkg::cnt_t'(ccs_pkg::MaxVertices);
      start_vertex_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccs_pkg::CfgVertexCount: vertex_count_q <= cfg_data_i;
        ccs_pkg::CfgStartVertex: start_vertex_q <= cfg_data_i[ccs_pkg::VidW-1:0];
        default: ;
      endcase
    end
  end

  // Effective vertex count and mask of vertices in use
  ccs_pkg::cnt_t n_eff;
  ccs_pkg::row_t active_mask;

  assign n_eff = (vertex_count_q > ccs_pkg::cnt_t'(ccs_pkg::MaxVertices)) ?
                 ccs_pkg::cnt_t'(ccs_pkg::MaxVertices) : vertex_count_q;

  always_comb begin
    for (int w = 0; w < ccs_pkg::MaxVertices; w++) begin
      active_mask[w] = ccs_pkg::cnt_t'(w) < n_eff;
    end
  end

  // Walk state
  ccs_pkg::vid_t edge_a_q, edge_a_d, edge_b_q, edge_b_d;
  ccs_pkg::row_t visited_q, visited_d;
  ccs_pkg::row_t scan_q, scan_d;
  ccs_pkg::cnt_t depth_q, depth_d;
  ccs_pkg::cnt_t size_q, size_d;

  // Adjacency memory with per-row valid bits (a row not valid reads as empty)
  ccs_pkg::row_t adj_mem [ccs_pkg::MaxVertices];
  ccs_pkg::row_t row_valid_q, row_valid_d;
  ccs_pkg::row_t adj_rd_q, adj_wdata, row_old;
  logic          adj_rd_vld_q, adj_we;
  ccs_pkg::vid_t adj_raddr, adj_waddr;

  // Pending stack memory
  ccs_pkg::vid_t stack_mem [ccs_pkg::MaxVertices];
  ccs_pkg::vid_t stack_rd_q, stack_raddr, stack_waddr, stack_wdata;
  logic          stack_we;

  // Output register
  logic          out_valid_q, out_valid_d, out_load;
  ccs_pkg::vid_t member_q;
  ccs_pkg::cnt_t out_size_q;
  logic          last_q;

  // Shared lowest-set-bit unit
  ccs_pkg::lsb_res_t lsb;

  ccs_lsb_unit u_lsb (
    .word_i (scan_q),
    .res_o  (lsb)
  );

  assign row_old = adj_rd_vld_q ? adj_rd_q : '0;
  assign in_ready_o = (state_q == SIdle);
  assign out_load = (state_q == SEmit) && lsb.found && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    edge_a_d    = edge_a_q;
    edge_b_d    = edge_b_q;
    visited_d   = visited_q;
    scan_d      = scan_q;
    depth_d     = depth_q;
    size_d      = size_q;
    row_valid_d = row_valid_q;
    adj_raddr   = edge_a_q;
    adj_we      = 1'b0;
    adj_waddr   = edge_a_q;
    adj_wdata   = row_old | (ccs_pkg::row_t'(1) << edge_b_q);
    stack_raddr = ccs_pkg::vid_t'(depth_q - ccs_pkg::cnt_t'(1));
    stack_we    = 1'b0;
    stack_waddr = depth_q[ccs_pkg::VidW-1:0];
    stack_wdata = lsb.idx;

    unique case (state_q)
      SIdle: begin
        adj_raddr = edge_from_i;
        if (in_valid_i) begin
          edge_a_d = edge_from_i;
          edge_b_d = edge_to_i;
          unique case (func_i)
            ccs_pkg::FuncAddEdge: begin
              if ((ccs_pkg::cnt_t'(edge_from_i) < n_eff) &&
                  (ccs_pkg::cnt_t'(edge_to_i) < n_eff)) begin
                state_d = SEdgeWrA;
              end
            end
            ccs_pkg::FuncQuery: begin
              visited_d = '0;
              depth_d   = '0;
              if (ccs_pkg::cnt_t'(start_vertex_q) < n_eff) begin
                visited_d   = ccs_pkg::row_t'(1) << start_vertex_q;
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = start_vertex_q;
                depth_d     = ccs_pkg::cnt_t'(1);
                size_d      = ccs_pkg::cnt_t'(1);
                state_d     = SPop;
              end
            end
            ccs_pkg::FuncClear: begin
              row_valid_d = '0;
              visited_d   = '0;
              depth_d     = '0;
            end
            default: ;
          endcase
        end
      end
      SEdgeWrA: begin
        adj_we               = 1'b1;
        row_valid_d[edge_a_q] = 1'b1;
        state_d              = SEdgeRdB;
      end
      SEdgeRdB: begin
        adj_raddr = edge_b_q;
        state_d   = SEdgeWrB;
      end
      SEdgeWrB: begin
        adj_we                = 1'b1;
        adj_waddr             = edge_b_q;
        adj_wdata             = row_old | (ccs_pkg::row_t'(1) << edge_a_q);
        row_valid_d[edge_b_q] = 1'b1;
        state_d               = SIdle;
      end
      SPop: begin
        if (depth_q == '0) begin
          scan_d  = visited_q;
          state_d = SEmit;
        end else begin
          depth_d = depth_q - ccs_pkg::cnt_t'(1);
          state_d = SAddr;
        end
      end
      SAddr: begin
        adj_raddr = stack_rd_q;
        state_d   = SRow;
      end
      SRow: begin
        scan_d    = row_old & active_mask & ~visited_q;
        visited_d = visited_q | (row_old & active_mask);
        state_d   = SPush;
      end
      SPush: begin
        if (lsb.found) begin
          stack_we = 1'b1;
          depth_d  = depth_q + ccs_pkg::cnt_t'(1);
          size_d   = size_q + ccs_pkg::cnt_t'(1);
          scan_d   = lsb.rest;
        end else begin
          state_d = SPop;
        end
      end
      SEmit: begin
        if (!lsb.found) begin
          state_d = SIdle;
        end else if (out_load) begin
          scan_d = lsb.rest;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      row_valid_q <= '0;
      depth_q     <= '0;
      size_q      <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      depth_q     <= depth_d;
      size_q      <= size_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    edge_a_q <= edge_a_d;
    edge_b_q <= edge_b_d;
    scan_q   <= scan_d;
    if (out_load) begin
      member_q   <= lsb.idx;
      out_size_q <= size_q;
      last_q     <= ~|lsb.rest;
    end
  end

  // Adjacency memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd_q     <= adj_mem[adj_raddr];
    adj_rd_vld_q <= row_valid_q[adj_raddr];
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  // Output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign member_vertex_o  = member_q;
  assign component_size_o = out_size_q;
  assign last_o           = last_q;

  // Checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= ccs_pkg::cnt_t'(ccs_pkg::MaxVertices))
    else $error("stack depth beyond vertex limit");

  a_push_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPush) |-> ((scan_q & ~visited_q) == '0))
    else $error("vertex pushed before being marked visited");

  a_emit_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit) |-> (size_q != '0))
    else $error("emitting members with zero component size");

endmodule

/* rtl/ccs_lsb_unit.sv */
// Lowest-set-bit unit: isolates, encodes and clears the lowest set bit of a row.
// Shared by the stack push and the member emit phases. Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_lsb_unit (
  input  ccs_pkg::row_t     word_i,
  output ccs_pkg::lsb_res_t res_o
);

  ccs_pkg::row_t iso;
  ccs_pkg::vid_t idx;

  // Two's complement trick picks out the lowest set bit
  assign iso = word_i & (~word_i + ccs_pkg::row_t'(1));

  // One-hot to binary: OR of the positions that carry each index bit
  always_comb begin
    idx = '0;
    for (int w = 0; w < ccs_pkg::MaxVertices; w++) begin
      if (iso[w]) begin
        idx = idx | ccs_pkg::vid_t'(w);
      end
    end
  end

  assign res_o.found = |word_i;
  assign res_o.idx   = idx;
  assign res_o.rest  = word_i & ~iso;

endmodule
